[rtl/core/fde_pkg.sv]
// ----------------------------------------------------------------------------
// fde_pkg
// shared types and constants of the directory entry decoder
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned ENTRY_WORDS   = 8;
    localparam int unsigned ENTRY_W       = WORD_W * ENTRY_WORDS;
    localparam int unsigned UNITS_PER_LFN = 13;
    localparam int unsigned SHORT_NAME_LEN = 11;

    localparam logic [7:0] LAST_LFN_FLAG = 8'h40;
    localparam logic [7:0] FREE_MARK     = 8'hE5;
    localparam logic [7:0] END_MARK      = 8'h00;
    localparam logic [7:0] MASK_RESET    = 8'h0F;

    typedef logic [ENTRY_WORDS-1:0][WORD_W-1:0] t_entry;

    typedef enum logic [1:0] {
        KIND_LFN_UNIT  = 2'd0,
        KIND_LFN_TERM  = 2'd1,
        KIND_SHORT_BYTE = 2'd2,
        KIND_SHORT_REC = 2'd3
    } t_kind;

    // byte offset of long-name unit k inside the entry
    function automatic logic [4:0] unit_offset(input logic [3:0] k);
        logic [4:0] off;
        unique case (k)
            4'd0:    off = 5'd1;
            4'd1:    off = 5'd3;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd9;
            4'd5:    off = 5'd14;
            4'd6:    off = 5'd16;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd22;
            4'd10:   off = 5'd24;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd30;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

[rtl/core/fde_buf.sv]
// ----------------------------------------------------------------------------
// fde_buf
// two-bank entry word memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fde_buf (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic        i_re,
    input  logic [3:0]  i_raddr,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [16];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fde_emit.sv]
// ----------------------------------------------------------------------------
// fde_emit
// classifies one buffered entry and sends its results one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module fde_emit #(
    parameter int unsigned MAX_ORDINAL = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_mask,
    input  logic                   i_load,
    input  fde_pkg::t_entry        i_entry,
    output logic                   o_free,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_kind,
    output logic [8:0]             o_position,
    output logic [15:0]            o_char_unit,
    output logic [7:0]             o_attributes,
    output logic [31:0]            o_first_cluster,
    output logic [31:0]            o_file_size,
    output logic                   o_in_use,
    output logic                   o_last
);

    logic [fde_pkg::ENTRY_W-1:0] r_entry;
    logic        r_e_valid;
    logic [3:0]  r_k;
    logic        r_o_valid;
    logic [1:0]  r_kind;
    logic [8:0]  r_pos;
    logic [15:0] r_char;
    logic [7:0]  r_attr;
    logic [31:0] r_clus;
    logic [31:0] r_size;
    logic        r_used;
    logic        r_last;

    logic [7:0]  b0, b11, ord;
    logic        is_long, bad_ord, emit;
    logic [3:0]  last_k;
    logic [8:0]  base;
    logic [4:0]  off;
    logic        advance;
    logic [1:0]  n_kind;
    logic [8:0]  n_pos;
    logic [15:0] n_char;
    logic [7:0]  n_attr;
    logic [31:0] n_clus;
    logic [31:0] n_size;
    logic        n_used;

    function automatic logic [7:0] get_byte(input logic [fde_pkg::ENTRY_W-1:0] e,
                                            input logic [4:0] idx);
        return e[{idx, 3'b000} +: 8];
    endfunction

    always_comb begin
        b0      = get_byte(r_entry, 5'd0);
        b11     = get_byte(r_entry, 5'd11);
        ord     = b0 & ~fde_pkg::LAST_LFN_FLAG;
        is_long = (b11 & i_mask) == i_mask;
        bad_ord = (ord == 8'd0) || (ord > 8'(MAX_ORDINAL));
        base    = 9'(({3'b000, ord[5:0]} - 9'd1) * 9'(fde_pkg::UNITS_PER_LFN));
        if (is_long) begin
            last_k = (b0 & fde_pkg::LAST_LFN_FLAG) != 8'd0
                   ? 4'(fde_pkg::UNITS_PER_LFN) : 4'(fde_pkg::UNITS_PER_LFN - 1);
        end else begin
            last_k = 4'(fde_pkg::SHORT_NAME_LEN);
        end
        emit    = r_e_valid && !(is_long && bad_ord);
        advance = !r_o_valid || !i_out_stall;
        off     = fde_pkg::unit_offset(r_k);

        n_kind  = fde_pkg::KIND_LFN_UNIT;
        n_pos   = 9'd0;
        n_char  = 16'd0;
        n_attr  = 8'd0;
        n_clus  = 32'd0;
        n_size  = 32'd0;
        n_used  = 1'b0;
        if (is_long) begin
            n_pos = base + 9'(r_k);
            if (r_k == 4'(fde_pkg::UNITS_PER_LFN)) begin
                n_kind = fde_pkg::KIND_LFN_TERM;
            end else begin
                n_kind = fde_pkg::KIND_LFN_UNIT;
                n_char = {get_byte(r_entry, off + 5'd1), get_byte(r_entry, off)};
            end
        end else if (r_k == 4'(fde_pkg::SHORT_NAME_LEN)) begin
            n_kind = fde_pkg::KIND_SHORT_REC;
            n_attr = b11;
            n_clus = {get_byte(r_entry, 5'd21), get_byte(r_entry, 5'd20),
                      get_byte(r_entry, 5'd27), get_byte(r_entry, 5'd26)};
            n_size = r_entry[255:224];
            n_used = (b0 != fde_pkg::FREE_MARK) && (b0 != fde_pkg::END_MARK);
        end else begin
            n_kind = fde_pkg::KIND_SHORT_BYTE;
            n_pos  = 9'(r_k);
            n_char = {8'h00, get_byte(r_entry, 5'(r_k))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_k       <= 4'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_o_valid <= emit;
            end
            if (r_e_valid && is_long && bad_ord) begin
                // bad ordinal: entry gives nothing
                r_e_valid <= 1'b0;
                r_k       <= 4'd0;
            end else if (advance && r_e_valid) begin
                if (r_k == last_k) begin
                    r_e_valid <= 1'b0;
                    r_k       <= 4'd0;
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end
            if (i_load) begin
                r_e_valid <= 1'b1;
                r_k       <= 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
        if (advance && emit) begin
            r_kind <= n_kind;
            r_pos  <= n_pos;
            r_char <= n_char;
            r_attr <= n_attr;
            r_clus <= n_clus;
            r_size <= n_size;
            r_used <= n_used;
            r_last <= (r_k == last_k);
        end
    end

    assign o_free          = !r_e_valid;
    assign o_out_valid     = r_o_valid;
    assign o_kind          = r_kind;
    assign o_position      = r_pos;
    assign o_char_unit     = r_char;
    assign o_attributes    = r_attr;
    assign o_first_cluster = r_clus;
    assign o_file_size     = r_size;
    assign o_in_use        = r_used;
    assign o_last          = r_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_e_valid)
        else $error("entry loaded while previous entry still sending");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> r_k <= 4'(fde_pkg::UNITS_PER_LFN))
        else $error("result index out of range");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && emit && advance && r_k == last_k && !i_load) |=> !r_e_valid)
        else $error("entry not released after its final result");

endmodule

[rtl/core/fat32_dir_entry_decoder_core.sv]
// ----------------------------------------------------------------------------
// fat32_dir_entry_decoder_core
// directory entry decoder: buffers 8-word entries, emits name units and records
// ----------------------------------------------------------------------------
// path: from the transfer of an entry's 8th word to its first result, via
//   loader start, 8 memory reads, capture, hand-off and the output register
// output: one result per cycle from the output register while not stalled; up
//   to 14 results per 8-word entry, with a gap at each entry hand-off; the
//   next entry is read from memory while the current one is sending
// reset: clears counters, bank flags and the mask (to 0x0F); memory not cleared
// ----------------------------------------------------------------------------
module fat32_dir_entry_decoder_core #(
    parameter int unsigned MAX_ORDINAL = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_entry_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [8:0]  o_position,
    output logic [15:0] o_char_unit,
    output logic [7:0]  o_attributes,
    output logic [31:0] o_first_cluster,
    output logic [31:0] o_file_size,
    output logic        o_in_use,
    output logic        o_last
);

    logic [7:0]  r_mask;
    logic [2:0]  r_wcnt;
    logic        r_wb;
    logic        r_rb;
    logic [1:0]  r_bank_full;
    logic        r_ld_active;
    logic [2:0]  r_rd_addr;
    logic        r_rd_pend;
    logic [2:0]  r_rd_idx;
    logic        r_ld_full;
    fde_pkg::t_entry r_ld_buf;

    logic        in_xfer;
    logic        start_ld;
    logic        emit_free;
    logic        do_load;
    logic [31:0] rdata;
    logic [1:0]  n_bank_full;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign start_ld  = !r_ld_active && !r_rd_pend && !r_ld_full && r_bank_full[r_rb];
    assign do_load   = r_ld_full && emit_free;
    assign o_in_stall = r_bank_full[r_wb];

    // writer fills one bank while the loader drains the other
    always_comb begin
        n_bank_full = r_bank_full;
        if (in_xfer && r_wcnt == 3'd7) begin
            n_bank_full[r_wb] = 1'b1;
        end
        if (r_rd_pend && r_rd_idx == 3'd7) begin
            n_bank_full[r_rb] = 1'b0;
        end
    end

    fde_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr ({r_wb, r_wcnt}),
        .i_wdata (i_entry_word),
        .i_re    (r_ld_active),
        .i_raddr ({r_rb, r_rd_addr}),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= fde_pkg::MASK_RESET;
            r_wcnt      <= 3'd0;
            r_wb        <= 1'b0;
            r_rb        <= 1'b0;
            r_bank_full <= 2'b00;
            r_ld_active <= 1'b0;
            r_rd_addr   <= 3'd0;
            r_rd_pend   <= 1'b0;
            r_rd_idx    <= 3'd0;
            r_ld_full   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            r_bank_full <= n_bank_full;
            // writer side
            if (in_xfer) begin
                r_wcnt <= r_wcnt + 3'd1;
                if (r_wcnt == 3'd7) begin
                    r_wb <= ~r_wb;
                end
            end
            // loader: read the full bank word by word
            if (start_ld) begin
                r_ld_active <= 1'b1;
                r_rd_addr   <= 3'd0;
            end else if (r_ld_active) begin
                r_rd_addr <= r_rd_addr + 3'd1;
                if (r_rd_addr == 3'd7) begin
                    r_ld_active <= 1'b0;
                end
            end
            r_rd_pend <= r_ld_active;
            r_rd_idx  <= r_rd_addr;
            if (r_rd_pend && r_rd_idx == 3'd7) begin
                r_ld_full <= 1'b1;
                r_rb      <= ~r_rb;
            end else if (do_load) begin
                r_ld_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_ld_buf[r_rd_idx] <= rdata;
        end
    end

    fde_emit #(
        .MAX_ORDINAL (MAX_ORDINAL)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mask          (r_mask),
        .i_load          (do_load),
        .i_entry         (r_ld_buf),
        .o_free          (emit_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_position      (o_position),
        .o_char_unit     (o_char_unit),
        .o_attributes    (o_attributes),
        .o_first_cluster (o_first_cluster),
        .o_file_size     (o_file_size),
        .o_in_use        (o_in_use),
        .o_last          (o_last)
    );

    a_loader_has_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_active |-> r_bank_full[r_rb])
        else $error("loader reading a bank that is not full");

    a_no_start_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ld_full |-> !r_ld_active)
        else $error("loader started while an entry is held");

    a_last_read_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && r_rd_idx == 3'd7) |=> r_ld_full)
        else $error("entry not marked held after its last read");

endmodule

[sim/fat32_dir_entry_checker.sv]
// ----------------------------------------------------------------------------
// fat32_dir_entry_checker
// watches both channels and the mask port of the directory entry decoder,
// decodes each completed 8-word entry on its own, and compares every output
// transfer field by field against the oldest pending expected result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat32_dir_entry_checker #(
    parameter int unsigned MAX_ORDINAL = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_entry_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [8:0]  i_position,
    input  logic [15:0] i_char_unit,
    input  logic [7:0]  i_attributes,
    input  logic [31:0] i_first_cluster,
    input  logic [31:0] i_file_size,
    input  logic        i_in_use,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words,
    output int          o_results
);

    typedef struct packed {
        fde_pkg::t_kind kind;
        logic [8:0]  position;
        logic [15:0] char_unit;
        logic [7:0]  attributes;
        logic [31:0] first_cluster;
        logic [31:0] file_size;
        logic        in_use;
        logic        last;
    } t_dir_result;

    // byte offset of each long-name unit, unit 0 in the low slot
    localparam logic [12:0][4:0] LFN_UNIT_OFFSET = {
        5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
        5'd14, 5'd9,  5'd7,  5'd5,  5'd3,  5'd1
    };

    logic [31:0]  entry_buf [7];
    logic [2:0]   word_cnt;
    logic [7:0]   attr_mask;
    t_dir_result  pending_results [$];

    task automatic decode_word(input logic [31:0] w);
        logic [255:0] ent;
        logic [7:0]   ord;
        logic [4:0]   off;
        int           base;
        t_dir_result  r;
        if (word_cnt != 3'd7) begin
            entry_buf[word_cnt] = w;
            word_cnt = word_cnt + 3'd1;
            return;
        end
        word_cnt = 3'd0;
        for (int k = 0; k < 7; k++) ent[32*k +: 32] = entry_buf[k];
        ent[224 +: 32] = w;

        if ((ent[88 +: 8] & attr_mask) == attr_mask) begin
            // ordinal keeps bit 7, only the last-entry flag is dropped
            ord = ent[7:0] & ~fde_pkg::LAST_LFN_FLAG;
            if (ord == 8'd0 || ord > MAX_ORDINAL) return;
            base = (int'(ord) - 1) * int'(fde_pkg::UNITS_PER_LFN);
            for (int i = 0; i < int'(fde_pkg::UNITS_PER_LFN); i++) begin
                off = LFN_UNIT_OFFSET[i];
                r = '0;
                r.kind = fde_pkg::KIND_LFN_UNIT;
                r.position = 9'(base + i);
                r.char_unit = {ent[8*off+8 +: 8], ent[8*off +: 8]};
                pending_results.push_back(r);
            end
            if ((ent[7:0] & fde_pkg::LAST_LFN_FLAG) != 8'd0) begin
                r = '0;
                r.kind = fde_pkg::KIND_LFN_TERM;
                r.position = 9'(base + int'(fde_pkg::UNITS_PER_LFN));
                pending_results.push_back(r);
            end
        end else begin
            for (int i = 0; i < int'(fde_pkg::SHORT_NAME_LEN); i++) begin
                r = '0;
                r.kind = fde_pkg::KIND_SHORT_BYTE;
                r.position = 9'(i);
                r.char_unit = {8'h00, ent[8*i +: 8]};
                pending_results.push_back(r);
            end
            r = '0;
            r.kind = fde_pkg::KIND_SHORT_REC;
            r.attributes = ent[88 +: 8];
            r.first_cluster = {ent[160 +: 16], ent[208 +: 16]};
            r.file_size = ent[224 +: 32];
            r.in_use = (ent[7:0] != fde_pkg::FREE_MARK) && (ent[7:0] != fde_pkg::END_MARK);
            pending_results.push_back(r);
        end
        pending_results[pending_results.size()-1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dir_result want;
        if (!i_rst_n) begin
            word_cnt  = 3'd0;
            attr_mask = fde_pkg::MASK_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_we) attr_mask = i_cfg_data;

            // compare before predicting so a same-edge result cannot match itself
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                o_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d position %0d", i_kind,
                           i_position);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_kind));
                    check_field("position", 32'(want.position), 32'(i_position));
                    check_field("char_unit", 32'(want.char_unit), 32'(i_char_unit));
                    check_field("attributes", 32'(want.attributes), 32'(i_attributes));
                    check_field("first_cluster", want.first_cluster, i_first_cluster);
                    check_field("file_size", want.file_size, i_file_size);
                    check_field("in_use", 32'(want.in_use), 32'(i_in_use));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end

            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                o_words++;
                decode_word(i_entry_word);
            end
        end
        o_pending = pending_results.size();
    end

endmodule

[sim/tb_fat32_dir_entry_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_fat32_dir_entry_decoder_core
// drives directed and random directory entries through the decoder under
// several attribute masks with random idling on both channels and one long
// output hold; the checker instance predicts and compares all results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fat32_dir_entry_decoder_core;

    localparam int unsigned MAX_ORD  = 20;
    localparam int ENTRIES_PER_PHASE = 10;
    localparam int DRAIN_CYCLES      = 30;
    localparam int HOLD_CYCLES       = 300;
    localparam int QUIET_LIMIT       = 3000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] entry_word;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [8:0]  position;
    logic [15:0] char_unit;
    logic [7:0]  attributes;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
    logic        in_use;
    logic        last;

    int   n_fail;
    int   n_pending;
    int   n_words;
    int   n_results;
    int   mask_writes;
    int   quiet_cycles;
    bit   idle_in;
    bit   idle_out;
    bit   long_hold;

    fat32_dir_entry_decoder_core #(
        .MAX_ORDINAL(MAX_ORD)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_entry_word   (entry_word),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (kind),
        .o_position     (position),
        .o_char_unit    (char_unit),
        .o_attributes   (attributes),
        .o_first_cluster(first_cluster),
        .o_file_size    (file_size),
        .o_in_use       (in_use),
        .o_last         (last)
    );

    fat32_dir_entry_checker #(
        .MAX_ORDINAL(MAX_ORD)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_entry_word   (entry_word),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_kind         (kind),
        .i_position     (position),
        .i_char_unit    (char_unit),
        .i_attributes   (attributes),
        .i_first_cluster(first_cluster),
        .i_file_size    (file_size),
        .i_in_use       (in_use),
        .i_last         (last),
        .o_fail_count   (n_fail),
        .o_pending      (n_pending),
        .o_words        (n_words),
        .o_results      (n_results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // random entry content with byte 0 and the attribute byte forced
    function automatic logic [255:0] entry_with(input logic [7:0] first,
                                                input logic [7:0] attr);
        logic [255:0] e;
        for (int k = 0; k < 8; k++) e[32*k +: 32] = $urandom;
        e[7:0]   = first;
        e[88 +: 8] = attr;
        return e;
    endfunction

    function automatic logic [255:0] random_entry(input logic [7:0] mask);
        logic [255:0] e;
        logic [7:0]   ord;
        logic [7:0]   attr;
        int           pick;
        for (int k = 0; k < 8; k++) e[32*k +: 32] = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            // long-name entry, mostly with a usable ordinal
            case ($urandom_range(0, 9))
                0:       ord = 8'd0;
                1:       ord = 8'($urandom_range(MAX_ORD + 1, 63));
                2:       ord = 8'h80 | 8'($urandom_range(1, MAX_ORD));
                default: ord = 8'($urandom_range(1, MAX_ORD));
            endcase
            if ($urandom_range(0, 1)) ord = ord | fde_pkg::LAST_LFN_FLAG;
            e[7:0] = ord;
            e[88 +: 8] = 8'($urandom) | mask;
        end else if (pick < 85) begin
            // short entry: knock out one mask bit so it cannot read as long, unless the mask is zero
            attr = 8'($urandom);
            if (mask != 8'd0 && (attr & mask) == mask) attr = attr & ~(mask & (~mask + 8'd1));
            e[88 +: 8] = attr;
            case ($urandom_range(0, 5))
                0:       e[7:0] = fde_pkg::FREE_MARK;
                1:       e[7:0] = fde_pkg::END_MARK;
                default: ;
            endcase
        end
        return e;
    endfunction

    task automatic send_word(input logic [31:0] w);
        int gap;
        gap = idle_in ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        entry_word <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    task automatic send_entry(input logic [255:0] e);
        for (int k = 0; k < 8; k++) send_word(e[32*k +: 32]);
    endtask

    // wait for every expected result, then let entries without results settle
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (n_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_mask(input logic [7:0] m);
        quiesce();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        mask_writes++;
    endtask

    task automatic run_random_phase(input logic [7:0] mask, input bit with_hold);
        set_mask(mask);
        for (int n = 0; n < ENTRIES_PER_PHASE; n++) begin
            if (n % 4 == 0 && !(with_hold && n >= 4)) begin
                idle_in  = $urandom_range(0, 3) != 0;
                idle_out = $urandom_range(0, 3) != 0;
            end
            if (with_hold && n == 4) begin
                // sender keeps pushing while the output side is held off
                idle_in   = 1'b0;
                long_hold = 1'b1;
            end
            send_entry(random_entry(mask));
        end
    endtask

    // output side
    initial begin : receiver
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = idle_out ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_stall === 1'b0) ||
            (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     QUIET_LIMIT, n_pending);
            $display("tb_fat32_dir_entry_decoder_core: FAIL");
            $finish;
        end
    end

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = 8'h00;
        in_valid     = 1'b0;
        entry_word   = 32'h0;
        mask_writes  = 0;
        idle_in      = 1'b1;
        idle_out     = 1'b1;
        long_hold    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed entries under the reset mask
        send_entry({256{1'b1}});                  // ordinal with bit 7 set: dropped
        send_entry({256{1'b0}});                  // end marker short entry
        send_entry(entry_with(8'h41, 8'h0F));     // first ordinal, last flag
        send_entry(entry_with(8'h54, 8'h0F));     // top ordinal, highest positions
        send_entry(entry_with(8'h40, 8'h3F));     // ordinal zero: dropped
        send_entry(entry_with(8'h15, 8'h0F));     // ordinal above limit: dropped
        send_entry(entry_with(fde_pkg::FREE_MARK, 8'h10)); // deleted short entry

        set_mask(8'h00);                          // everything reads as long-name
        send_entry(entry_with(8'h03, 8'h00));
        set_mask(8'hFF);
        send_entry(entry_with(8'h45, 8'hFF));
        send_entry(entry_with(8'h41, 8'hFE));

        run_random_phase(fde_pkg::MASK_RESET, 1'b1);
        run_random_phase(8'h00, 1'b0);
        run_random_phase(8'hFF, 1'b0);
        run_random_phase(8'($urandom_range(1, 254)), 1'b0);
        run_random_phase(fde_pkg::MASK_RESET, 1'b0);

        quiesce();
        $display("run covered %0d words and %0d results over %0d mask writes,",
                 n_words, n_results, mask_writes);
        $display("with random idling on both sides and one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (n_fail == 0 && n_pending == 0) begin
            $display("tb_fat32_dir_entry_decoder_core: PASS");
        end else begin
            $display("tb_fat32_dir_entry_decoder_core: FAIL");
        end
        $finish;
    end

endmodule

[fat32_dir_entry_decoder_core.f]
rtl/core/fde_pkg.sv
rtl/core/fde_buf.sv
rtl/core/fde_emit.sv
rtl/core/fat32_dir_entry_decoder_core.sv
sim/fat32_dir_entry_checker.sv
sim/tb_fat32_dir_entry_decoder_core.sv
